// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the checker file of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted (active low).
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A stalled item keeps its valid high and the given signal stable.
`define ASSERT_HOLD(label, clk, rst_n, vld, rdy, sig, msg) \
  `ASSERT_PROP(label, clk, rst_n, (vld) && !(rdy) |=> (vld) && $stable(sig), msg)

`endif

// ----- rtl/core/srt_pkg.sv -----
// Types and constants of the sorted record table.
package srt_pkg;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned KEY_W    = 30;
  localparam int unsigned NAME_W   = 64;
  localparam int unsigned GRADE_W  = 11;
  localparam int unsigned AVG_W    = 12;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned POS_W    = 5;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_DUPLICATE = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 3'd4;

  // One table entry as it sits in the record memory.
  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [NAME_W-1:0]  name;
    logic [GRADE_W-1:0] grade_one;
    logic [GRADE_W-1:0] grade_two;
    logic [AVG_W-1:0]   average;
  } rec_t;

endpackage

// ----- rtl/core/srt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module srt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- rtl/core/sorted_record_table.sv -----
// Sorted record table: insert, remove and search over a key-ordered record memory.
//
// Input channel (in_valid_i / in_ready_o) carries one command item: cmd_i selects
// insert, remove or search (code three acts as search), key_i is the sort key and
// name_word_i, grade_one_i, grade_two_i are the record body used by insert.
// Output channel (out_valid_o / out_ready_i) returns exactly one result item per
// command: status, position, the matched record on a search hit, and the entry
// count after the operation.
// Steps: the scan reads entries from index 0, each with a memory read and then a
// key compare, until a key not below the given key or the entry count is reached;
// insert and remove then move entries, each with a read and then a write, and an
// insert ends with the slot write of the new record. A full table on insert or an
// empty table on remove skips the scan. With no stall the result turns valid at
// the same edge that raises in_ready_o again. The single-port-read record memory
// sets this order of steps.
// One item is worked at a time; in_ready_o is high only while the sequencer idles.
// A result waits in the output register while the receiver stalls; the next item
// may be accepted and scanned meanwhile, and holds before its own result.
// Reset empties the table (count to zero) and drops any pending result; memory
// contents are not cleared since entries past the count are never read.
module sorted_record_table #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [srt_pkg::CMD_W-1:0]        cmd_i,
  input  logic [srt_pkg::KEY_W-1:0]        key_i,
  input  logic [srt_pkg::NAME_W-1:0]       name_word_i,
  input  logic [srt_pkg::GRADE_W-1:0]      grade_one_i,
  input  logic [srt_pkg::GRADE_W-1:0]      grade_two_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [srt_pkg::STATUS_W-1:0]     status_o,
  output logic [srt_pkg::POS_W-1:0]        position_o,
  output logic [srt_pkg::NAME_W-1:0]       found_name_o,
  output logic [srt_pkg::GRADE_W-1:0]      found_grade_one_o,
  output logic [srt_pkg::GRADE_W-1:0]      found_grade_two_o,
  output logic [srt_pkg::AVG_W-1:0]        found_average_o,
  output logic [srt_pkg::POS_W-1:0]        entry_count_o
);

  // Count and index width (holds CAPACITY itself) and memory address width.
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned RW = $bits(srt_pkg::rec_t);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_LREAD  = 7'b0000010,  // issue read of entry idx, or stop at the end
    S_LCMP   = 7'b0000100,  // compare entry idx against the key
    S_SREAD  = 7'b0001000,  // read the neighbor of the slot being moved
    S_SWRITE = 7'b0010000,  // write it one slot over
    S_SINS   = 7'b0100000,  // store the new record at the insertion point
    S_RESP   = 7'b1000000   // hand the result to the output register
  } state_e;

  state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] idx_q, idx_d;    // scan index, ends as position
  logic [CW-1:0] sidx_q, sidx_d;  // slot written by the shift

  // Latched command item.
  logic [srt_pkg::CMD_W-1:0]   cmd_q, cmd_d;
  logic [srt_pkg::KEY_W-1:0]   key_q, key_d;
  logic [srt_pkg::NAME_W-1:0]  name_q, name_d;
  logic [srt_pkg::GRADE_W-1:0] g1_q, g1_d;
  logic [srt_pkg::GRADE_W-1:0] g2_q, g2_d;

  // Result under construction.
  logic [srt_pkg::STATUS_W-1:0] res_status_q, res_status_d;
  srt_pkg::rec_t                res_rec_q, res_rec_d;

  // Output register.
  logic                         out_valid_q, out_valid_d;
  logic [srt_pkg::STATUS_W-1:0] out_status_q, out_status_d;
  logic [srt_pkg::POS_W-1:0]    out_pos_q, out_pos_d;
  logic [srt_pkg::POS_W-1:0]    out_count_q, out_count_d;
  srt_pkg::rec_t                out_rec_q, out_rec_d;

  // Record memory port.
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  srt_pkg::rec_t ram_wdata, rd_rec;
  logic [RW-1:0] ram_rdata;

  logic is_ins, is_rem;
  logic loc_now, loc_hit;

  assign is_ins = (cmd_q == srt_pkg::CMD_INSERT);
  assign is_rem = (cmd_q == srt_pkg::CMD_REMOVE);
  assign rd_rec = srt_pkg::rec_t'(ram_rdata);

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    idx_d        = idx_q;
    sidx_d       = sidx_q;
    cmd_d        = cmd_q;
    key_d        = key_q;
    name_d       = name_q;
    g1_d         = g1_q;
    g2_d         = g2_q;
    res_status_d = res_status_q;
    res_rec_d    = res_rec_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_pos_d    = out_pos_q;
    out_count_d  = out_count_q;
    out_rec_d    = out_rec_q;
    ram_we       = 1'b0;
    ram_waddr    = sidx_q[AW-1:0];
    ram_wdata    = rd_rec;
    ram_raddr    = idx_q[AW-1:0];
    loc_now      = 1'b0;
    loc_hit      = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d        = cmd_i;
          key_d        = key_i;
          name_d       = name_word_i;
          g1_d         = grade_one_i;
          g2_d         = grade_two_i;
          res_status_d = srt_pkg::STATUS_OK;
          res_rec_d    = '0;
          idx_d        = '0;
          if (cmd_i == srt_pkg::CMD_INSERT && count_q >= CW'(CAPACITY)) begin
            res_status_d = srt_pkg::STATUS_FULL;
            state_d      = S_RESP;
          end else if (cmd_i == srt_pkg::CMD_REMOVE && count_q == '0) begin
            res_status_d = srt_pkg::STATUS_EMPTY;
            state_d      = S_RESP;
          end else begin
            state_d = S_LREAD;
          end
        end
      end
      S_LREAD: begin
        if (idx_q >= count_q) begin
          loc_now = 1'b1;
        end else begin
          state_d = S_LCMP;
        end
      end
      S_LCMP: begin
        if (rd_rec.key < key_q) begin
          idx_d   = idx_q + 1'b1;
          state_d = S_LREAD;
        end else begin
          loc_now = 1'b1;
          loc_hit = (rd_rec.key == key_q);
        end
      end
      S_SREAD: begin
        ram_raddr = is_ins ? AW'(sidx_q - 1'b1) : AW'(sidx_q + 1'b1);
        state_d   = S_SWRITE;
      end
      S_SWRITE: begin
        ram_we = 1'b1;
        if (is_ins) begin
          sidx_d  = sidx_q - 1'b1;
          state_d = (sidx_d > idx_q) ? S_SREAD : S_SINS;
        end else begin
          // count_q is already the post-remove count here
          sidx_d  = sidx_q + 1'b1;
          state_d = (sidx_d < count_q) ? S_SREAD : S_RESP;
        end
      end
      S_SINS: begin
        ram_we              = 1'b1;
        ram_waddr           = idx_q[AW-1:0];
        ram_wdata.key       = key_q;
        ram_wdata.name      = name_q;
        ram_wdata.grade_one = g1_q;
        ram_wdata.grade_two = g2_q;
        ram_wdata.average   = {1'b0, g1_q} + {1'b0, g2_q};
        count_d             = count_q + 1'b1;
        state_d             = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_pos_d    = srt_pkg::POS_W'(idx_q);
          out_count_d  = srt_pkg::POS_W'(count_q);
          out_rec_d    = res_rec_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Scan finished: idx_q holds the match index or the insertion point.
    if (loc_now) begin
      if (is_ins) begin
        if (loc_hit) begin
          res_status_d = srt_pkg::STATUS_DUPLICATE;
          state_d      = S_RESP;
        end else begin
          sidx_d  = count_q;
          state_d = (count_q > idx_q) ? S_SREAD : S_SINS;
        end
      end else if (is_rem) begin
        if (loc_hit) begin
          count_d = count_q - 1'b1;
          sidx_d  = idx_q;
          state_d = ((idx_q + 1'b1) < count_q) ? S_SREAD : S_RESP;
        end else begin
          res_status_d = srt_pkg::STATUS_NOT_FOUND;
          state_d      = S_RESP;
        end
      end else begin
        if (loc_hit) begin
          res_rec_d = rd_rec;
        end else begin
          res_status_d = srt_pkg::STATUS_NOT_FOUND;
        end
        state_d = S_RESP;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    sidx_q       <= sidx_d;
    cmd_q        <= cmd_d;
    key_q        <= key_d;
    name_q       <= name_d;
    g1_q         <= g1_d;
    g2_q         <= g2_d;
    res_status_q <= res_status_d;
    res_rec_q    <= res_rec_d;
    out_status_q <= out_status_d;
    out_pos_q    <= out_pos_d;
    out_count_q  <= out_count_d;
    out_rec_q    <= out_rec_d;
  end

  srt_ram #(
    .WIDTH (RW),
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_rec_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_ready_o        = (state_q == S_IDLE);
  assign out_valid_o       = out_valid_q;
  assign status_o          = out_status_q;
  assign position_o        = out_pos_q;
  assign entry_count_o     = out_count_q;
  assign found_name_o      = out_rec_q.name;
  assign found_grade_one_o = out_rec_q.grade_one;
  assign found_grade_two_o = out_rec_q.grade_two;
  assign found_average_o   = out_rec_q.average;

endmodule

// ----- rtl/core/srt_checker.sv -----
// Port-level assertion checker for the sorted record table, with its bind.
`include "assert_macros.svh"

module srt_checker #(
  parameter int unsigned CAPACITY = 16
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [srt_pkg::STATUS_W-1:0] status_o,
  input logic [srt_pkg::NAME_W-1:0]   found_name_o,
  input logic [srt_pkg::GRADE_W-1:0]  found_grade_one_o,
  input logic [srt_pkg::GRADE_W-1:0]  found_grade_two_o,
  input logic [srt_pkg::AVG_W-1:0]    found_average_o,
  input logic [srt_pkg::POS_W-1:0]    entry_count_o
);

  logic [srt_pkg::AVG_W-1:0] grade_sum;
  logic                      in_fire;

  assign grade_sum = {1'b0, found_grade_one_o} + {1'b0, found_grade_two_o};
  assign in_fire   = in_valid_i && in_ready_o;

  `ASSERT_HOLD(a_out_hold, clk_i, rst_ni, out_valid_o, out_ready_i, status_o, "result dropped while stalled")

  `ASSERT_PROP(a_status_code, clk_i, rst_ni, out_valid_o |-> status_o <= srt_pkg::STATUS_EMPTY, "bad status code")

  `ASSERT_PROP(a_avg_sum, clk_i, rst_ni, out_valid_o |-> found_average_o == grade_sum, "average is not the grade sum")

  `ASSERT_PROP(a_miss_zero, clk_i, rst_ni, out_valid_o && status_o != srt_pkg::STATUS_OK |-> found_name_o == '0 && found_average_o == '0, "record shown without a match")

  `ASSERT_PROP(a_empty_count, clk_i, rst_ni, out_valid_o && (status_o == srt_pkg::STATUS_EMPTY || in_fire) |-> entry_count_o <= CAPACITY, "entry count out of range")

endmodule

bind sorted_record_table srt_checker #(
  .CAPACITY (CAPACITY)
) u_srt_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_ready_o        (in_ready_o),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .status_o          (status_o),
  .found_name_o      (found_name_o),
  .found_grade_one_o (found_grade_one_o),
  .found_grade_two_o (found_grade_two_o),
  .found_average_o   (found_average_o),
  .entry_count_o     (entry_count_o)
);
